// ===== hdl/ple_pkg.sv =====
// ---------------------------------------------------------------------------
// Positional list engine package
// Shared widths, action and status codes, and the structs that pass between
// the top level, the storage cells and the reduction tree.
// ---------------------------------------------------------------------------
package ple_pkg;

	localparam int unsigned POS_W       = 7;
	localparam int unsigned VALUE_W     = 32;
	localparam int unsigned COUNT_OUT_W = 7;
	// Wide enough for any cell index up to the largest supported capacity.
	localparam int unsigned IDX_CMP_W   = 13;

	typedef enum logic [1:0] {
		ACT_INSERT = 2'd0,
		ACT_REMOVE = 2'd1,
		ACT_SWAP   = 2'd2,
		ACT_QUERY  = 2'd3
	} action_t;

	typedef enum logic [1:0] {
		STAT_OK    = 2'd0,
		STAT_RANGE = 2'd1,
		STAT_FULL  = 2'd2
	} status_t;

	// Command broadcast to every cell of the row.
	typedef struct packed {
		logic               apply;
		action_t            action;
		logic [POS_W-1:0]   idx_a;
		logic [POS_W-1:0]   idx_b;
		logic [VALUE_W-1:0] val_a;
		logic [VALUE_W-1:0] val_b;
	} cell_cmd_t;

	// Root of the reduction tree, already in result form.
	typedef struct packed {
		logic                   valid;
		logic [VALUE_W-1:0]     max_value;
		logic [COUNT_OUT_W-1:0] max_position;
		logic                   is_sorted;
		logic                   found;
		logic [VALUE_W-1:0]     pick_a;
		logic [VALUE_W-1:0]     pick_b;
	} summary_t;

endpackage

// ===== hdl/ple_cell.sv =====
// ---------------------------------------------------------------------------
// Positional list engine storage cell
// Holds one entry; on an applied command it loads a new value, takes its
// left neighbor (insert shift) or its right neighbor (remove shift).
// ---------------------------------------------------------------------------
module ple_cell
	import ple_pkg::*;
#(
	parameter int unsigned INDEX = 0
) (
	input  logic               clk,
	input  cell_cmd_t          cmd,
	input  logic [VALUE_W-1:0] left_value,
	input  logic [VALUE_W-1:0] right_value,
	output logic [VALUE_W-1:0] value
);

	logic [VALUE_W-1:0] value_q;
	logic [VALUE_W-1:0] value_d;
	logic               at_a;
	logic               at_b;
	logic               above_a;

	assign at_a    = IDX_CMP_W'(INDEX) == IDX_CMP_W'(cmd.idx_a);
	assign at_b    = IDX_CMP_W'(INDEX) == IDX_CMP_W'(cmd.idx_b);
	assign above_a = IDX_CMP_W'(INDEX) >  IDX_CMP_W'(cmd.idx_a);

	always_comb begin
		value_d = value_q;
		if (cmd.apply) begin
			unique case (cmd.action)
				ACT_INSERT: begin
					if (at_a) begin
						value_d = cmd.val_a;
					end else if (above_a) begin
						value_d = left_value;
					end
				end
				ACT_REMOVE: begin
					if (at_a || above_a) begin
						value_d = right_value;
					end
				end
				ACT_SWAP: begin
					if (at_a) begin
						value_d = cmd.val_a;
					end else if (at_b) begin
						value_d = cmd.val_b;
					end
				end
				ACT_QUERY: begin
					value_d = value_q;
				end
				default: begin
					value_d = value_q;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		value_q <= value_d;
	end

	assign value = value_q;

endmodule

// ===== hdl/ple_tree.sv =====
// ---------------------------------------------------------------------------
// Positional list engine reduction tree
// Registered binary tree over the cell row: first maximum and its position,
// non-decreasing flag, presence of the key, and two selected entries.
// ---------------------------------------------------------------------------
module ple_tree
	import ple_pkg::*;
#(
	parameter int unsigned CAPACITY = 2
) (
	input  logic                                clk,
	input  logic [CAPACITY-1:0][VALUE_W-1:0]    values,
	input  logic [$clog2(CAPACITY+1)-1:0]       count,
	input  logic [POS_W-1:0]                    idx_a,
	input  logic [POS_W-1:0]                    idx_b,
	input  logic [VALUE_W-1:0]                  key,
	output summary_t                            summary
);

	localparam int unsigned LEVELS = $clog2(CAPACITY);
	localparam int unsigned LEAVES = 2 ** LEVELS;
	localparam int unsigned CMPW   = $clog2(2 * CAPACITY + 1);

	typedef struct packed {
		logic               valid;
		logic [VALUE_W-1:0] maxv;
		logic [LEVELS-1:0]  pos;
		logic               sorted;
		logic               found;
		logic [VALUE_W-1:0] head;
		logic [VALUE_W-1:0] tail;
		logic [VALUE_W-1:0] pick_a;
		logic [VALUE_W-1:0] pick_b;
	} node_t;

	// Valid leaves form a prefix, so a valid right child implies a valid left.
	function automatic node_t combine(node_t l, node_t r);
		node_t o;
		o = l;
		if (r.valid) begin
			if ($signed(r.maxv) > $signed(l.maxv)) begin
				o.maxv = r.maxv;
				o.pos  = r.pos;
			end
			o.sorted = l.sorted & r.sorted & !($signed(r.head) < $signed(l.tail));
			o.found  = l.found | r.found;
			o.tail   = r.tail;
		end
		o.pick_a = l.pick_a | r.pick_a;
		o.pick_b = l.pick_b | r.pick_b;
		return o;
	endfunction

	node_t leaf    [LEAVES];
	node_t inner_q [1:LEAVES-1];

	for (genvar i = 0; i < LEAVES; i++) begin : g_leaf
		logic [VALUE_W-1:0] v;
		logic               lv;
		if (i < CAPACITY) begin : g_real
			assign v = values[i];
		end else begin : g_pad
			assign v = '0;
		end
		assign lv = CMPW'(i) < CMPW'(count);
		assign leaf[i] = '{
			valid:  lv,
			maxv:   v,
			pos:    LEVELS'(i),
			sorted: 1'b1,
			found:  lv && (v == key),
			head:   v,
			tail:   v,
			pick_a: (IDX_CMP_W'(i) == IDX_CMP_W'(idx_a)) ? v : '0,
			pick_b: (IDX_CMP_W'(i) == IDX_CMP_W'(idx_b)) ? v : '0
		};
	end

	for (genvar k = 1; k < LEAVES; k++) begin : g_node
		node_t lc;
		node_t rc;
		if (2 * k >= LEAVES) begin : g_from_leaf
			assign lc = leaf[2 * k - LEAVES];
			assign rc = leaf[2 * k + 1 - LEAVES];
		end else begin : g_from_node
			assign lc = inner_q[2 * k];
			assign rc = inner_q[2 * k + 1];
		end
		always_ff @(posedge clk) begin
			inner_q[k] <= combine(lc, rc);
		end
	end

	logic [LEVELS:0] root_pos1;

	assign root_pos1 = (LEVELS + 1)'(inner_q[1].pos) + (LEVELS + 1)'(1);

	always_comb begin
		summary.valid        = inner_q[1].valid;
		summary.max_value    = inner_q[1].valid ? inner_q[1].maxv : '1;
		summary.max_position = inner_q[1].valid ? COUNT_OUT_W'(root_pos1) : '0;
		summary.is_sorted    = inner_q[1].valid ? inner_q[1].sorted : 1'b1;
		summary.found        = inner_q[1].valid & inner_q[1].found;
		summary.pick_a       = inner_q[1].pick_a;
		summary.pick_b       = inner_q[1].pick_b;
	end

endmodule

// ===== hdl/positional_list_engine_unit.sv =====
// ---------------------------------------------------------------------------
// Positional list engine
// Ordered list of signed 32-bit entries with insert, remove, swap and query.
// ---------------------------------------------------------------------------
// The list lives in a row of CAPACITY cells that shift one place per step on
// insert or remove, and a registered reduction tree of L = ceil(log2
// CAPACITY) levels summarizes it. One item is processed at a time. Insert
// and query pass through S_APPLY and S_SCAN to the result; remove and swap
// first read their entries through the tree in S_PICK. The tree depth sets
// how long S_PICK and S_SCAN wait. The result waits in an output register,
// so the next item is taken while it is pending.
module positional_list_engine_unit
	import ple_pkg::*;
#(
	parameter int unsigned CAPACITY = 64
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	input  logic [47:0] s_axis_tdata,  // position_a, position_b, item_value, 2 zero bits
	input  logic [1:0]  s_axis_tuser,  // action
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	output logic [79:0] m_axis_tdata,  // removed_value, entry_count, max_value,
	                                   // max_position, is_sorted, value_found
	output logic [1:0]  m_axis_tuser   // status
);

	localparam int unsigned CW     = $clog2(CAPACITY + 1);
	localparam int unsigned LEVELS = $clog2(CAPACITY);
	localparam int unsigned LW     = $clog2(LEVELS + 1);
	localparam int unsigned CMPW   = (CW > POS_W ? CW : POS_W) + 1;

	typedef enum logic [3:0] {
		S_IDLE  = 4'b0001,
		S_PICK  = 4'b0010,
		S_APPLY = 4'b0100,
		S_SCAN  = 4'b1000
	} state_t;

	state_t                 state_q;
	logic [LW-1:0]          wait_q;
	logic [CW-1:0]          count_q;
	logic                   m_valid_q;

	action_t                action_q;
	logic [POS_W-1:0]       pa_q;
	logic [POS_W-1:0]       pb_q;
	logic [VALUE_W-1:0]     item_q;
	logic [VALUE_W-1:0]     va_q;
	logic [VALUE_W-1:0]     vb_q;
	status_t                status_q;
	logic [VALUE_W-1:0]     removed_q;

	status_t                out_status_q;
	logic [VALUE_W-1:0]     out_removed_q;
	logic [COUNT_OUT_W-1:0] out_count_q;
	logic [VALUE_W-1:0]     out_max_q;
	logic [COUNT_OUT_W-1:0] out_maxpos_q;
	logic                   out_sorted_q;
	logic                   out_found_q;

	logic                   s_fire;
	action_t                in_action;
	logic                   wait_done;
	logic                   out_free;
	logic [CMPW-1:0]        pa_ext;
	logic [CMPW-1:0]        pb_ext;
	logic [CMPW-1:0]        n_ext;
	logic                   pa_bad;
	logic                   pb_bad;
	logic                   full;
	status_t                status_d;
	logic                   ok;
	logic [CW-1:0]          count_d;
	cell_cmd_t              cell_cmd;
	summary_t               summary;
	logic [CAPACITY-1:0][VALUE_W-1:0] cell_value;

	assign s_axis_tready = (state_q == S_IDLE);
	assign s_fire        = s_axis_tvalid && s_axis_tready;
	assign in_action     = action_t'(s_axis_tuser);
	assign wait_done     = (wait_q == LW'(LEVELS));
	assign out_free      = !m_valid_q || m_axis_tready;

	// Range and fullness checks on the latched item against the current count.
	assign pa_ext = CMPW'(pa_q);
	assign pb_ext = CMPW'(pb_q);
	assign n_ext  = CMPW'(count_q);
	assign pa_bad = (pa_q == '0) || (pa_ext > n_ext);
	assign pb_bad = (pb_q == '0) || (pb_ext > n_ext);
	assign full   = (count_q == CW'(CAPACITY));

	always_comb begin
		status_d = STAT_OK;
		count_d  = count_q;
		unique case (action_q)
			ACT_INSERT: begin
				if ((pa_q == '0) || (pa_ext > n_ext + CMPW'(1))) begin
					status_d = STAT_RANGE;
				end else if (full) begin
					status_d = STAT_FULL;
				end else begin
					count_d = count_q + CW'(1);
				end
			end
			ACT_REMOVE: begin
				if (pa_bad) begin
					status_d = STAT_RANGE;
				end else begin
					count_d = count_q - CW'(1);
				end
			end
			ACT_SWAP: begin
				if (pa_bad || pb_bad) begin
					status_d = STAT_RANGE;
				end
			end
			ACT_QUERY: begin
				status_d = STAT_OK;
			end
			default: begin
				status_d = STAT_OK;
			end
		endcase
	end

	assign ok = (status_d == STAT_OK);

	always_comb begin
		cell_cmd.apply  = (state_q == S_APPLY) && ok;
		cell_cmd.action = action_q;
		cell_cmd.idx_a  = pa_q - POS_W'(1);
		cell_cmd.idx_b  = pb_q - POS_W'(1);
		cell_cmd.val_a  = (action_q == ACT_INSERT) ? item_q : vb_q;
		cell_cmd.val_b  = va_q;
	end

	for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
		logic [VALUE_W-1:0] lv;
		logic [VALUE_W-1:0] rv;
		if (i == 0) begin : g_first
			assign lv = cell_value[i];
		end else begin : g_left
			assign lv = cell_value[i - 1];
		end
		if (i == CAPACITY - 1) begin : g_last
			assign rv = cell_value[i];
		end else begin : g_right
			assign rv = cell_value[i + 1];
		end
		ple_cell #(
			.INDEX(i)
		) u_cell (
			.clk        (clk),
			.cmd        (cell_cmd),
			.left_value (lv),
			.right_value(rv),
			.value      (cell_value[i])
		);
	end

	ple_tree #(
		.CAPACITY(CAPACITY)
	) u_tree (
		.clk    (clk),
		.values (cell_value),
		.count  (count_q),
		.idx_a  (cell_cmd.idx_a),
		.idx_b  (cell_cmd.idx_b),
		.key    (item_q),
		.summary(summary)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= S_IDLE;
			wait_q    <= '0;
			count_q   <= '0;
			m_valid_q <= 1'b0;
		end else begin
			unique case (state_q)
				S_IDLE: begin
					if (s_fire) begin
						wait_q <= '0;
						if (in_action == ACT_REMOVE || in_action == ACT_SWAP) begin
							state_q <= S_PICK;
						end else begin
							state_q <= S_APPLY;
						end
					end
				end
				S_PICK: begin
					if (wait_done) begin
						state_q <= S_APPLY;
					end else begin
						wait_q <= wait_q + LW'(1);
					end
				end
				S_APPLY: begin
					count_q <= count_d;
					wait_q  <= '0;
					state_q <= S_SCAN;
				end
				S_SCAN: begin
					if (!wait_done) begin
						wait_q <= wait_q + LW'(1);
					end else if (out_free) begin
						state_q <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
			// A new result takes the output register when it is empty or as the old one leaves it.
			if (state_q == S_SCAN && wait_done && out_free) begin
				m_valid_q <= 1'b1;
			end else if (m_axis_tready) begin
				m_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (s_fire) begin
			action_q <= in_action;
			pa_q     <= s_axis_tdata[6:0];
			pb_q     <= s_axis_tdata[13:7];
			item_q   <= s_axis_tdata[45:14];
		end
		if (state_q == S_PICK && wait_done) begin
			va_q <= summary.pick_a;
			vb_q <= summary.pick_b;
		end
		if (state_q == S_APPLY) begin
			status_q  <= status_d;
			removed_q <= (action_q == ACT_REMOVE && ok) ? va_q : '1;
		end
		if (state_q == S_SCAN && wait_done && out_free) begin
			out_status_q  <= status_q;
			out_removed_q <= removed_q;
			out_count_q   <= COUNT_OUT_W'(count_q);
			out_max_q     <= summary.max_value;
			out_maxpos_q  <= summary.max_position;
			out_sorted_q  <= summary.is_sorted;
			out_found_q   <= summary.found;
		end
	end

	assign m_axis_tvalid = m_valid_q;
	assign m_axis_tuser  = out_status_q;
	assign m_axis_tdata  = {out_found_q, out_sorted_q, out_maxpos_q, out_max_q,
	                        out_count_q, out_removed_q};

	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		CMPW'(count_q) <= CMPW'(CAPACITY))
		else $error("entry count exceeds capacity");

	a_count_only_on_apply: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q != S_APPLY) |=> $stable(count_q))
		else $error("entry count changed outside the apply step");

	a_insert_grows: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_APPLY && ok && action_q == ACT_INSERT)
		|=> (count_q == $past(count_q) + CW'(1)))
		else $error("successful insert did not add one entry");

	a_result_from_scan: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(m_valid_q) |-> $past(state_q == S_SCAN))
		else $error("result presented without a finished scan");

	a_accept_starts_work: assert property (@(posedge clk) disable iff (!arst_n)
		s_fire |=> (state_q == S_PICK || state_q == S_APPLY))
		else $error("accepted transfer did not start processing");

endmodule

// ===== tb/positional_list_engine_unit_test.sv =====
// ---------------------------------------------------------------------------
// Positional list engine testbench
// Drives insert, remove, swap and query transfers into the list engine. A
// behavioral copy of the list predicts every result, and each output transfer
// is compared field by field against the oldest prediction. The run uses
// directed corner cases, a fill-to-capacity pass, random mixes under several
// idling patterns, and a long output hold-off that backs up the input.
// ---------------------------------------------------------------------------
module positional_list_engine_unit_test;
	import ple_pkg::*;

	localparam int CAP         = 64;
	localparam int STALL_LIMIT = 3000;
	localparam int DRAIN_WAIT  = 40;

	typedef struct {
		status_t     status;
		logic [31:0] removed_value;
		logic [6:0]  entry_count;
		logic [31:0] max_value;
		logic [6:0]  max_position;
		logic        is_sorted;
		logic        value_found;
	} list_outcome_t;

	logic        clk = 1'b0;
	logic        arst_n;
	logic        s_axis_tvalid;
	logic        s_axis_tready;
	logic [47:0] s_axis_tdata;
	logic [1:0]  s_axis_tuser;
	logic        m_axis_tvalid;
	logic        m_axis_tready = 1'b0;
	logic [79:0] m_axis_tdata;
	logic [1:0]  m_axis_tuser;

	// Behavioral copy of the list.
	logic signed [31:0] list_mem [CAP];
	int                 list_len = 0;

	list_outcome_t pending_outcomes [$];
	int            error_count   = 0;
	int            send_idle_pct = 0;
	int            recv_stall_pct = 0;
	int            hold_left     = 0;
	int            quiet_cycles  = 0;

	positional_list_engine_unit #(.CAPACITY(CAP)) dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.s_axis_tuser  (s_axis_tuser),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.m_axis_tuser  (m_axis_tuser)
	);

	always #5 clk = ~clk;

	// Applies one action to the list copy and returns the result it should give.
	function automatic list_outcome_t apply_list_action(action_t act, int pa, int pb,
			logic signed [31:0] val);
		list_outcome_t r;
		int i;
		int n;
		logic signed [31:0] t;
		r.status        = STAT_OK;
		r.removed_value = '1;
		n = list_len;
		case (act)
			ACT_INSERT: begin
				if (pa < 1 || pa > n + 1) begin
					r.status = STAT_RANGE;
				end else if (n >= CAP) begin
					r.status = STAT_FULL;
				end else begin
					for (i = n; i >= pa; i--)
						list_mem[i] = list_mem[i - 1];
					list_mem[pa - 1] = val;
					list_len = n + 1;
				end
			end
			ACT_REMOVE: begin
				if (pa < 1 || pa > n) begin
					r.status = STAT_RANGE;
				end else begin
					r.removed_value = list_mem[pa - 1];
					for (i = pa; i < n; i++)
						list_mem[i - 1] = list_mem[i];
					list_len = n - 1;
				end
			end
			ACT_SWAP: begin
				if (pa < 1 || pa > n || pb < 1 || pb > n) begin
					r.status = STAT_RANGE;
				end else begin
					t                = list_mem[pa - 1];
					list_mem[pa - 1] = list_mem[pb - 1];
					list_mem[pb - 1] = t;
				end
			end
			default: ;
		endcase

		n = list_len;
		r.entry_count  = 7'(n);
		r.max_value    = '1;
		r.max_position = '0;
		r.is_sorted    = 1'b1;
		r.value_found  = 1'b0;
		if (n > 0) begin
			r.max_value    = list_mem[0];
			r.max_position = 7'd1;
		end
		for (i = 0; i < n; i++) begin
			if (i > 0) begin
				// Strict compare keeps the first occurrence of the maximum.
				if (list_mem[i] > $signed(r.max_value)) begin
					r.max_value    = list_mem[i];
					r.max_position = 7'(i + 1);
				end
				if (list_mem[i] < list_mem[i - 1])
					r.is_sorted = 1'b0;
			end
			if (list_mem[i] == val)
				r.value_found = 1'b1;
		end
		return r;
	endfunction

	// Offers one item, waits for its transfer and records the predicted result.
	task automatic send_item(action_t act, int pa, int pb, logic [31:0] val);
		logic [6:0] pa_bits;
		logic [6:0] pb_bits;
		pa_bits = pa[6:0];
		pb_bits = pb[6:0];
		while ($urandom_range(99) < send_idle_pct) begin
			s_axis_tvalid <= 1'b0;
			@(posedge clk);
		end
		s_axis_tvalid <= 1'b1;
		s_axis_tdata  <= {2'b00, val, pb_bits, pa_bits};
		s_axis_tuser  <= act;
		@(posedge clk);
		while (!s_axis_tready)
			@(posedge clk);
		pending_outcomes.push_back(apply_list_action(act, pa_bits, pb_bits, val));
	endtask

	function automatic logic [31:0] pick_value();
		int sel;
		sel = $urandom_range(99);
		if (sel < 35)
			return $urandom_range(8) - 4;
		if (sel < 55 && list_len > 0)
			return list_mem[$urandom_range(list_len - 1)];
		if (sel < 70) begin
			case ($urandom_range(3))
				0:       return 32'h8000_0000;
				1:       return 32'h7FFF_FFFF;
				2:       return 32'h0000_0000;
				default: return 32'hFFFF_FFFF;
			endcase
		end
		return $urandom();
	endfunction

	// One random item; grow_pct sets the share of inserts so the list rises and falls.
	task automatic random_item(int grow_pct);
		action_t     act;
		int          pa;
		int          pb;
		int          i;
		int          r;
		logic [31:0] val;
		val = pick_value();
		r   = $urandom_range(99);
		if ($urandom_range(99) < grow_pct)
			act = ACT_INSERT;
		else if (r < 45)
			act = ACT_REMOVE;
		else if (r < 80)
			act = ACT_SWAP;
		else
			act = ACT_QUERY;
		pa = $urandom_range(127);
		pb = $urandom_range(127);
		// Most items carry legal positions; the rest keep the raw noise.
		if ($urandom_range(99) >= 12 && act != ACT_QUERY) begin
			case (act)
				ACT_INSERT: begin
					pa = $urandom_range(list_len + 1, 1);
					if ($urandom_range(3) == 0) begin
						// Ordered insert, so that sorted runs build up.
						pa = list_len + 1;
						for (i = list_len - 1; i >= 0; i--)
							if (list_mem[i] > $signed(val))
								pa = i + 1;
					end
				end
				ACT_REMOVE: begin
					pa = (list_len > 0) ? $urandom_range(list_len, 1) : 1;
				end
				default: begin
					pa = (list_len > 0) ? $urandom_range(list_len, 1) : 1;
					pb = (list_len > 0) ? $urandom_range(list_len, 1) : 1;
				end
			endcase
		end
		send_item(act, pa, pb, val);
	endtask

	task automatic test_directed();
		send_item(ACT_QUERY,  0,   0,   32'h0000_0000);
		send_item(ACT_REMOVE, 1,   0,   32'h0000_0000);
		send_item(ACT_INSERT, 0,   0,   32'h1234_5678);
		send_item(ACT_INSERT, 2,   0,   32'h1234_5678);
		send_item(ACT_INSERT, 1,   127, 32'h7FFF_FFFF);
		send_item(ACT_INSERT, 1,   0,   32'h8000_0000);
		send_item(ACT_INSERT, 3,   0,   32'h0000_0000);
		send_item(ACT_INSERT, 2,   0,   32'hFFFF_FFFF);
		send_item(ACT_QUERY,  127, 127, 32'h8000_0000);
		send_item(ACT_SWAP,   1,   4,   32'h0000_0000);
		send_item(ACT_SWAP,   2,   2,   32'hFFFF_FFFF);
		send_item(ACT_SWAP,   0,   1,   32'h0000_0000);
		send_item(ACT_SWAP,   1,   5,   32'h0000_0000);
		send_item(ACT_SWAP,   127, 1,   32'h0000_0000);
		send_item(ACT_INSERT, 5,   0,   32'h7FFF_FFFF);
		send_item(ACT_REMOVE, 0,   0,   32'h7FFF_FFFF);
		send_item(ACT_REMOVE, 6,   0,   32'h7FFF_FFFF);
		send_item(ACT_REMOVE, 127, 0,   32'h7FFF_FFFF);
		send_item(ACT_REMOVE, 5,   0,   32'h7FFF_FFFF);
		send_item(ACT_REMOVE, 1,   0,   32'h8000_0000);
		send_item(ACT_INSERT, 127, 0,   32'h0000_0001);
		send_item(ACT_QUERY,  0,   0,   32'h5555_5555);
		send_item(ACT_QUERY,  0,   0,   32'hAAAA_AAAA);
	endtask

	// Fills the list to capacity, probes the full cases, then empties it.
	task automatic test_fill_and_drain();
		while (list_len < CAP)
			send_item(ACT_INSERT, $urandom_range(list_len + 1, 1), $urandom_range(127),
				pick_value());
		send_item(ACT_INSERT, $urandom_range(CAP, 1), 0, 32'h0000_0007);
		send_item(ACT_INSERT, CAP + 1, 0, 32'h0000_0007);
		send_item(ACT_INSERT, CAP + 2, 0, 32'h0000_0007);
		send_item(ACT_SWAP, 1, CAP, pick_value());
		send_item(ACT_SWAP, CAP + 1, 1, pick_value());
		send_item(ACT_REMOVE, CAP + 1, 0, pick_value());
		send_item(ACT_QUERY, 0, 0, pick_value());
		send_item(ACT_REMOVE, CAP, 0, pick_value());
		send_item(ACT_INSERT, CAP, 0, 32'h7FFF_FFFF);
		while (list_len > 0)
			send_item(ACT_REMOVE, $urandom_range(list_len, 1), $urandom_range(127),
				pick_value());
		send_item(ACT_REMOVE, 1, 0, 32'h0000_0000);
		send_item(ACT_SWAP, 1, 1, 32'h0000_0000);
	endtask

	task automatic test_random_mix(int n_items, int idle_pct, int stall_pct);
		int k;
		int grow_pct;
		send_idle_pct  = idle_pct;
		recv_stall_pct = stall_pct;
		grow_pct       = 70;
		for (k = 0; k < n_items; k++) begin
			if (k % 60 == 59)
				grow_pct = (grow_pct == 70) ? 25 : 70;
			random_item(grow_pct);
		end
	endtask

	// The output is held off long enough that the engine backs up its input.
	task automatic test_output_backpressure();
		int k;
		send_idle_pct  = 0;
		recv_stall_pct = 0;
		s_axis_tvalid <= 1'b0;
		@(negedge clk);
		hold_left = 400;
		@(posedge clk);
		for (k = 0; k < 40; k++)
			random_item(55);
	endtask

	task automatic check_field(string name, logic [31:0] want, logic [31:0] got);
		if (got !== want) begin
			$display("%0t: %s expected %h, got %h", $time, name, want, got);
			error_count++;
		end
	endtask

	// Output side: checks each transfer and drives a randomly stalling ready.
	always @(posedge clk) begin : result_check
		list_outcome_t want;
		if (arst_n && m_axis_tvalid && m_axis_tready) begin
			if (pending_outcomes.size() == 0) begin
				$display("%0t: result transfer with nothing expected, got %h / %h",
					$time, m_axis_tuser, m_axis_tdata);
				error_count++;
			end else begin
				want = pending_outcomes.pop_front();
				check_field("status",        32'(want.status),       32'(m_axis_tuser));
				check_field("removed_value", want.removed_value,     m_axis_tdata[31:0]);
				check_field("entry_count",   32'(want.entry_count),  32'(m_axis_tdata[38:32]));
				check_field("max_value",     want.max_value,         m_axis_tdata[70:39]);
				check_field("max_position",  32'(want.max_position), 32'(m_axis_tdata[77:71]));
				check_field("is_sorted",     32'(want.is_sorted),    32'(m_axis_tdata[78]));
				check_field("value_found",   32'(want.value_found),  32'(m_axis_tdata[79]));
			end
		end
		if (hold_left > 0) begin
			hold_left--;
			m_axis_tready <= 1'b0;
		end else begin
			m_axis_tready <= ($urandom_range(99) >= recv_stall_pct);
		end
	end

	always @(posedge clk) begin
		if (!arst_n || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
			quiet_cycles <= 0;
		end else if (quiet_cycles >= STALL_LIMIT) begin
			$display("%0t: no transfer for %0d cycles", $time, quiet_cycles);
			$display("SCOREBOARD MISMATCH");
			$finish;
		end else begin
			quiet_cycles <= quiet_cycles + 1;
		end
	end

	initial begin
		arst_n        = 1'b0;
		s_axis_tvalid = 1'b0;
		s_axis_tdata  = '0;
		s_axis_tuser  = ACT_QUERY;
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_directed();
		test_fill_and_drain();
		test_random_mix(220, 0, 0);
		test_random_mix(200, 86, 0);
		test_random_mix(200, 0, 86);
		test_random_mix(200, 32, 32);
		test_output_backpressure();
		s_axis_tvalid <= 1'b0;

		while (pending_outcomes.size() != 0)
			@(posedge clk);
		repeat (DRAIN_WAIT) @(posedge clk);
		if (error_count == 0)
			$display("SCOREBOARD CLEAN");
		else
			$display("SCOREBOARD MISMATCH");
		$finish;
	end

endmodule

// ===== files.f =====
hdl/ple_pkg.sv
hdl/ple_cell.sv
hdl/ple_tree.sv
hdl/positional_list_engine_unit.sv
tb/positional_list_engine_unit_test.sv
